@@ rtl/ssep_pkg.sv @@
// Shared types and constants for the event-stream parser.
// Depends on nothing; every other file but ssep_ram imports it.
package ssep_pkg;

  // Event name store.
  localparam int MAX_EVENT_NAME = 32;
  localparam int NAME_AW = (MAX_EVENT_NAME > 1) ? $clog2(MAX_EVENT_NAME) : 1;
  localparam int NAME_LW = $clog2(MAX_EVENT_NAME + 1);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_NAME = 2'd1,
    KIND_DISP = 2'd2,
    KIND_DONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    OP_DATA  = 3'd0,  // emit a data byte (newline included)
    OP_NAME  = 3'd1,  // append a byte to the event name
    OP_CLEAR = 3'd2,  // clear event name and cut flag
    OP_DISP  = 3'd3,  // dispatch: name bytes then marker
    OP_DONE  = 3'd4   // flush done marker
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] ch;
    logic       flag;  // flush_dispatched for OP_DONE
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_in;
  } req_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_out;
    logic       name_truncated;
    logic       flush_dispatched;
    logic       last;
  } evt_t;

endpackage

@@ rtl/ssep_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/ssep_front.sv @@
// Front end: accepts input words, tracks line state, issues commands.
// Depends on ssep_pkg; feeds ssep_fifo.
module ssep_front import ssep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_push_cmd
);

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_NAME    = 3'd1,
    PH_VFIRST  = 3'd2,
    PH_VALUE   = 3'd3,
    PH_COMMENT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    FLD_NONE  = 2'd0,
    FLD_DATA  = 2'd1,
    FLD_EVENT = 2'd2
  } field_t;

  localparam logic [3:0] M_DATA  = 4'd4;
  localparam logic [3:0] M_EVENT = 4'd9;
  localparam logic [3:0] M_DEAD  = 4'd15;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] match;
    field_t     field;
    logic       cr;
    logic       seen;
    logic       dnon;
  } fst_t;

  typedef struct packed {
    fst_t s;
    logic cv;
    cmd_t cmd;
    logic disp;
  } step_t;

  function automatic cmd_t mk(cmd_op_t op, logic [7:0] ch, logic flag);
    cmd_t c;
    c.op   = op;
    c.ch   = ch;
    c.flag = flag;
    c.last = 1'b0;
    return c;
  endfunction

  function automatic logic [3:0] adv(logic [3:0] m, logic [7:0] c);
    logic [3:0] r;
    r = M_DEAD;
    case (m)
      4'd0: begin
        if (c == "d") r = 4'd1;
        else if (c == "e") r = 4'd5;
      end
      4'd1: if (c == "a") r = 4'd2;
      4'd2: if (c == "t") r = 4'd3;
      4'd3: if (c == "a") r = 4'd4;
      4'd5: if (c == "v") r = 4'd6;
      4'd6: if (c == "e") r = 4'd7;
      4'd7: if (c == "n") r = 4'd8;
      4'd8: if (c == "t") r = 4'd9;
      default: r = M_DEAD;
    endcase
    return r;
  endfunction

  function automatic step_t value_byte(step_t r, logic [7:0] c);
    step_t o;
    o = r;
    if (r.s.field == FLD_DATA) begin
      o.cv     = 1'b1;
      o.cmd    = mk(OP_DATA, c, 1'b0);
      o.s.dnon = 1'b1;
    end else if (r.s.field == FLD_EVENT) begin
      o.cv  = 1'b1;
      o.cmd = mk(OP_NAME, c, 1'b0);
    end
    return o;
  endfunction

  // One ordinary byte of a line.
  function automatic step_t plain(fst_t s, logic [7:0] c);
    step_t r;
    r.s    = s;
    r.cv   = 1'b0;
    r.cmd  = mk(OP_DATA, 8'h00, 1'b0);
    r.disp = 1'b0;
    case (s.phase)
      PH_START: begin
        if (c == CH_COLON) begin
          r.s.phase = PH_COMMENT;
        end else begin
          r.s.phase = PH_NAME;
          r.s.match = adv(4'd0, c);
        end
      end
      PH_NAME: begin
        if (c == CH_COLON) begin
          r.s.seen  = 1'b1;
          r.s.phase = PH_VFIRST;
          if (s.match == M_DATA) begin
            r.s.field = FLD_DATA;
            if (s.dnon) begin
              r.cv  = 1'b1;
              r.cmd = mk(OP_DATA, CH_LF, 1'b0);
            end
          end else if (s.match == M_EVENT) begin
            r.s.field = FLD_EVENT;
            r.cv      = 1'b1;
            r.cmd     = mk(OP_CLEAR, 8'h00, 1'b0);
          end else begin
            r.s.field = FLD_NONE;
          end
        end else begin
          r.s.match = adv(s.match, c);
        end
      end
      PH_VFIRST: begin
        r.s.phase = PH_VALUE;
        if (c != CH_SPACE) r = value_byte(r, c);
      end
      PH_VALUE: r = value_byte(r, c);
      default: ;
    endcase
    return r;
  endfunction

  // End of line; a held CR is dropped.
  function automatic step_t end_line(fst_t s);
    step_t r;
    r.s    = s;
    r.cv   = 1'b0;
    r.cmd  = mk(OP_DATA, 8'h00, 1'b0);
    r.disp = 1'b0;
    case (s.phase)
      PH_START: begin
        if (s.seen) begin
          r.cv     = 1'b1;
          r.cmd    = mk(OP_DISP, 8'h00, 1'b0);
          r.s.dnon = 1'b0;
          r.s.seen = 1'b0;
          r.disp   = 1'b1;
        end
      end
      PH_NAME: begin
        r.s.seen = 1'b1;
        if (s.match == M_DATA) begin
          if (s.dnon) begin
            r.cv  = 1'b1;
            r.cmd = mk(OP_DATA, CH_LF, 1'b0);
          end
        end else if (s.match == M_EVENT) begin
          r.cv  = 1'b1;
          r.cmd = mk(OP_CLEAR, 8'h00, 1'b0);
        end
      end
      default: ;
    endcase
    r.s.phase = PH_START;
    r.s.match = 4'd0;
    r.s.field = FLD_NONE;
    r.s.cr    = 1'b0;
    return r;
  endfunction

  fst_t       st;
  fst_t       st_next;
  cmd_t       cl [3];
  logic [1:0] n;
  cmd_t       pend [2];
  logic [1:0] pend_cnt;
  logic       accept;

  always_comb begin
    step_t      p;
    logic       disp;
    logic       found;
    logic [1:0] lst;
    p       = '0;
    st_next = st;
    n       = 2'd0;
    disp    = 1'b0;
    found   = 1'b0;
    lst     = 2'd0;
    for (int i = 0; i < 3; i++) begin
      cl[i] = mk(OP_DATA, 8'h00, 1'b0);
    end
    if (req.req_type) begin
      if (st_next.phase != PH_START || st_next.cr) begin
        p       = end_line(st_next);
        st_next = p.s;
        disp    = p.disp;
        if (p.cv) begin
          cl[n] = p.cmd;
          n     = n + 2'd1;
        end
      end
      if (st_next.seen) begin
        cl[n]        = mk(OP_DISP, 8'h00, 1'b0);
        n            = n + 2'd1;
        st_next.dnon = 1'b0;
        st_next.seen = 1'b0;
        disp         = 1'b1;
      end
      cl[n] = mk(OP_DONE, 8'h00, disp);
      n     = n + 2'd1;
    end else if (req.byte_in == CH_LF) begin
      p       = end_line(st_next);
      st_next = p.s;
      if (p.cv) begin
        cl[n] = p.cmd;
        n     = n + 2'd1;
      end
    end else begin
      if (st_next.cr) begin
        st_next.cr = 1'b0;
        p          = plain(st_next, CH_CR);
        st_next    = p.s;
        if (p.cv) begin
          cl[n] = p.cmd;
          n     = n + 2'd1;
        end
      end
      if (req.byte_in == CH_CR) begin
        st_next.cr = 1'b1;
      end else begin
        p       = plain(st_next, req.byte_in);
        st_next = p.s;
        if (p.cv) begin
          cl[n] = p.cmd;
          n     = n + 2'd1;
        end
      end
    end
    // last goes on the final command that produces a result word
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n && (cl[i].op == OP_DATA || cl[i].op == OP_DISP ||
                        cl[i].op == OP_DONE)) begin
        found = 1'b1;
        lst   = 2'(i);
      end
    end
    if (found) cl[lst].last = 1'b1;
  end

  assign req_ready  = (pend_cnt == 2'd0) && !q_full;
  assign accept     = req_valid && req_ready;
  assign q_push     = accept ? (n != 2'd0) : (pend_cnt != 2'd0 && !q_full);
  assign q_push_cmd = accept ? cl[0] : pend[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase <= PH_START;
      st.match <= 4'd0;
      st.field <= FLD_NONE;
      st.cr    <= 1'b0;
      st.seen  <= 1'b0;
      st.dnon  <= 1'b0;
      pend_cnt <= 2'd0;
    end else if (accept) begin
      st       <= st_next;
      pend_cnt <= (n == 2'd0) ? 2'd0 : n - 2'd1;
    end else if (pend_cnt != 2'd0 && !q_full) begin
      pend_cnt <= pend_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend[0] <= cl[1];
      pend[1] <= cl[2];
    end else if (pend_cnt != 2'd0 && !q_full) begin
      pend[0] <= pend[1];
    end
  end

endmodule

@@ rtl/ssep_fifo.sv @@
// Short command queue between front and back end.
// Depends on ssep_pkg.
module ssep_fifo import ssep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  function automatic logic [QUEUE_AW-1:0] inc(logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= inc(wr_ptr);
      if (pop) rd_ptr <= inc(rd_ptr);
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

endmodule

@@ rtl/ssep_back.sv @@
// Back end: executes queued commands, owns the event name store and the
// output register. Depends on ssep_pkg and ssep_ram.
module ssep_back import ssep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  cmd_t q_head,
  output logic q_pop,
  output logic evt_valid,
  input  logic evt_ready,
  output evt_t evt
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_NAME = 2'd1,
    ST_MARK = 2'd2
  } state_t;

  state_t             state;
  logic [NAME_LW-1:0] name_len;
  logic               name_cut;
  logic [NAME_AW-1:0] idx;
  logic               disp_last;

  logic               out_free;
  logic               evt_load;
  logic [NAME_LW-1:0] idx_inc;
  logic               more;
  logic               has_room;
  logic               wr_en;
  logic               rd_en;
  logic [NAME_AW-1:0] rd_addr;
  logic [7:0]         rd_data;

  assign out_free = !evt_valid || evt_ready;
  assign q_pop    = (state == ST_IDLE) && !q_empty && out_free;
  assign idx_inc  = NAME_LW'(idx) + 1'b1;
  assign more     = idx_inc < name_len;
  assign has_room = name_len < NAME_LW'(MAX_EVENT_NAME);
  // a new word goes into the output register this cycle
  assign evt_load = (q_pop && (q_head.op == OP_DATA || q_head.op == OP_DONE)) ||
                    (state == ST_NAME && out_free) || (state == ST_MARK && out_free);

  always_comb begin
    wr_en   = q_pop && q_head.op == OP_NAME && has_room;
    rd_en   = 1'b0;
    rd_addr = '0;
    if (q_pop && q_head.op == OP_DISP) begin
      rd_en = 1'b1;
    end else if (state == ST_NAME && out_free && more) begin
      rd_en   = 1'b1;
      rd_addr = idx_inc[NAME_AW-1:0];
    end
  end

  ssep_ram #(
    .WIDTH (8),
    .DEPTH (MAX_EVENT_NAME)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (name_len[NAME_AW-1:0]),
    .wr_data (q_head.ch),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      evt_valid <= 1'b0;
      name_len  <= '0;
      name_cut  <= 1'b0;
    end else begin
      if (evt_ready && !evt_load) evt_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_head.op)
              OP_DATA: begin
                evt_valid <= 1'b1;
                evt <= '{kind: KIND_DATA, byte_out: q_head.ch, name_truncated: 1'b0,
                         flush_dispatched: 1'b0, last: q_head.last};
              end
              OP_NAME: begin
                if (has_room) name_len <= name_len + 1'b1;
                else name_cut <= 1'b1;
              end
              OP_CLEAR: begin
                name_len <= '0;
                name_cut <= 1'b0;
              end
              OP_DISP: begin
                disp_last <= q_head.last;
                idx       <= '0;
                state     <= (name_len == '0) ? ST_MARK : ST_NAME;
              end
              OP_DONE: begin
                evt_valid <= 1'b1;
                evt <= '{kind: KIND_DONE, byte_out: 8'h00, name_truncated: 1'b0,
                         flush_dispatched: q_head.flag, last: q_head.last};
              end
              default: ;
            endcase
          end
        end
        ST_NAME: begin
          if (out_free) begin
            evt_valid <= 1'b1;
            evt <= '{kind: KIND_NAME, byte_out: rd_data, name_truncated: 1'b0,
                     flush_dispatched: 1'b0, last: 1'b0};
            if (more) idx <= idx_inc[NAME_AW-1:0];
            else state <= ST_MARK;
          end
        end
        ST_MARK: begin
          if (out_free) begin
            evt_valid <= 1'b1;
            evt <= '{kind: KIND_DISP, byte_out: 8'h00, name_truncated: name_cut,
                     flush_dispatched: 1'b0, last: disp_last};
            name_len <= '0;
            name_cut <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/sse_event_stream_parser_core.sv @@
// Server-sent-events stream parser, top level.
// Depends on ssep_pkg, ssep_front, ssep_fifo, ssep_back, ssep_ram.
//
// Usage
//   req channel (req_valid/req_ready/req): one word per stream byte, or a
//   flush word (req_type = 1) at end of stream.
//   evt channel (evt_valid/evt_ready/evt): result words - data bytes,
//   event name bytes, dispatch markers and flush-done markers. The final
//   word caused by an input word carries last.
// Timing
//   Data path: a data byte is written to the queue at the edge that accepts
//   it and moves to the output register when the back end pops it; a busy
//   back end or a held output register delays the pop.
//   Throughput: one input word per cycle while the queue has room and each
//   word yields at most one queue command. A byte that releases a held CR
//   yields up to two commands and a flush up to three; the extra ones are
//   pushed from a pending buffer while req_ready is held low. A dispatch
//   occupies the back end while the name is read out (the pop only starts
//   the first RAM read) and sends name length plus one words; the four-entry
//   command queue absorbs input meanwhile and req_ready drops once it fills.
// Reset
//   Synchronous rst returns the line state to line start and empties the
//   queue and output register. The name RAM is not cleared: the name length
//   resets to zero so no stale entry is ever sent.
// Back-pressure
//   A stalled evt holds the output register; the back end stops popping,
//   the queue fills and req_ready then falls. Nothing is dropped.
module sse_event_stream_parser_core import ssep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic evt_valid,
  input  logic evt_ready,
  output evt_t evt
);

  // Front to queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  // Queue to back
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  // Front end: line parsing, one command per cycle into the queue while it has room.
  ssep_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd)
  );

  // Decoupling queue: lets the front keep parsing while a dispatch drains.
  ssep_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back end: name store, dispatch sequencing, output register.
  ssep_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

`ifndef SYNTH
  // A flush always ends its own output.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.kind == KIND_DONE |-> evt.last)
    else $error("flush-done word without last");

  // Name bytes are always followed by a dispatch marker.
  a_name_not_last: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt.kind == KIND_NAME |-> !evt.last)
    else $error("name byte marked last");

  // Input is only taken when the queue can hold its first command.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !q_full)
    else $error("req_ready with full queue");

  // The queue is never pushed while full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("push into full queue");
`endif

endmodule

@@ bench/ssep_stream_checker.sv @@
// Checker for the event-stream parser: watches both channels, predicts the evt words.
// Depends on ssep_pkg for the req/evt word types, the kind codes and the character constants.
`timescale 1ns / 1ps
module ssep_stream_checker import ssep_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic evt_valid,
  input  logic evt_ready,
  input  evt_t evt,
  output int   mismatches,
  output int   outstanding
);

  typedef enum logic [2:0] {
    LINE_START, LINE_NAME, LINE_AFTER_COLON, LINE_VALUE, LINE_COMMENT
  } line_phase_t;

  typedef enum logic [1:0] {FIELD_NONE, FIELD_DATA, FIELD_EVENT} field_t;

  // Field-name match progress: 1..4 walk "data", 5..9 walk "event".
  localparam logic [3:0] MATCH_START = 4'd0;
  localparam logic [3:0] MATCH_DATA  = 4'd4;
  localparam logic [3:0] MATCH_EVENT = 4'd9;
  localparam logic [3:0] MATCH_DEAD  = 4'd15;

  localparam logic [31:0] DATA_WORD  = "data";
  localparam logic [39:0] EVENT_WORD = "event";

  line_phase_t line_phase;
  field_t      line_field;
  logic [3:0]  name_match;
  bit          cr_held;
  bit          field_seen;
  bit          data_nonempty;
  logic [7:0]  name_store [MAX_EVENT_NAME];
  int          name_len;
  bit          name_cut;

  evt_t pending_evts [$];
  int   errors = 0;

  function automatic logic [3:0] next_match(logic [3:0] m, logic [7:0] c);
    if (m == MATCH_START) begin
      if (c == DATA_WORD[31:24]) return 4'd1;
      if (c == EVENT_WORD[39:32]) return 4'd5;
      return MATCH_DEAD;
    end
    if (m >= 4'd1 && m <= 4'd3)
      return (c == DATA_WORD[8*(3-m) +: 8]) ? m + 4'd1 : MATCH_DEAD;
    if (m >= 4'd5 && m <= 4'd8)
      return (c == EVENT_WORD[8*(8-m) +: 8]) ? m + 4'd1 : MATCH_DEAD;
    return MATCH_DEAD;
  endfunction

  function automatic void push_evt(kind_t k, logic [7:0] b, logic cut, logic fd);
    evt_t w;
    w.kind = k;
    w.byte_out = b;
    w.name_truncated = cut;
    w.flush_dispatched = fd;
    w.last = 1'b0;
    pending_evts.insert(pending_evts.size(), w);
  endfunction

  function automatic void clear_name();
    name_len = 0;
    name_cut = 1'b0;
  endfunction

  function automatic void value_byte(logic [7:0] c);
    if (line_field == FIELD_DATA) begin
      push_evt(KIND_DATA, c, 1'b0, 1'b0);
      data_nonempty = 1'b1;
    end else if (line_field == FIELD_EVENT) begin
      if (name_len < MAX_EVENT_NAME) begin
        name_store[name_len] = c;
        name_len++;
      end else begin
        name_cut = 1'b1;
      end
    end
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    case (line_phase)
      LINE_START: begin
        if (c == CH_COLON) begin
          line_phase = LINE_COMMENT;
        end else begin
          line_phase = LINE_NAME;
          name_match = next_match(MATCH_START, c);
        end
      end
      LINE_NAME: begin
        if (c == CH_COLON) begin
          field_seen = 1'b1;
          if (name_match == MATCH_DATA) begin
            line_field = FIELD_DATA;
            if (data_nonempty) push_evt(KIND_DATA, CH_LF, 1'b0, 1'b0);
          end else if (name_match == MATCH_EVENT) begin
            line_field = FIELD_EVENT;
            clear_name();
          end else begin
            line_field = FIELD_NONE;
          end
          line_phase = LINE_AFTER_COLON;
        end else begin
          name_match = next_match(name_match, c);
        end
      end
      LINE_AFTER_COLON: begin
        line_phase = LINE_VALUE;
        if (c != CH_SPACE) value_byte(c);
      end
      LINE_VALUE: value_byte(c);
      default: ;
    endcase
  endfunction

  function automatic bit dispatch_event();
    int i;
    if (!field_seen) return 1'b0;
    for (i = 0; i < name_len; i++) push_evt(KIND_NAME, name_store[i], 1'b0, 1'b0);
    push_evt(KIND_DISP, 8'h00, name_cut, 1'b0);
    data_nonempty = 1'b0;
    clear_name();
    field_seen = 1'b0;
    return 1'b1;
  endfunction

  // Closes the current line; a held CR is simply dropped.
  function automatic bit end_line();
    bit sent;
    sent = 1'b0;
    if (line_phase == LINE_START) begin
      sent = dispatch_event();
    end else if (line_phase == LINE_NAME) begin
      field_seen = 1'b1;
      if (name_match == MATCH_DATA) begin
        if (data_nonempty) push_evt(KIND_DATA, CH_LF, 1'b0, 1'b0);
      end else if (name_match == MATCH_EVENT) begin
        clear_name();
      end
    end
    line_phase = LINE_START;
    name_match = MATCH_START;
    line_field = FIELD_NONE;
    cr_held = 1'b0;
    return sent;
  endfunction

  function automatic void parse_req(req_t w);
    int   depth_before;
    bit   sent;
    evt_t tail;
    depth_before = pending_evts.size();
    if (w.req_type) begin
      sent = 1'b0;
      if (line_phase != LINE_START || cr_held) sent = end_line();
      if (field_seen) begin
        if (dispatch_event()) sent = 1'b1;
      end
      push_evt(KIND_DONE, 8'h00, 1'b0, sent);
    end else if (w.byte_in == CH_LF) begin
      void'(end_line());
    end else begin
      if (cr_held) begin
        cr_held = 1'b0;
        plain_byte(CH_CR);
      end
      if (w.byte_in == CH_CR) cr_held = 1'b1;
      else plain_byte(w.byte_in);
    end
    if (pending_evts.size() > depth_before) begin
      tail = pending_evts[pending_evts.size() - 1];
      tail.last = 1'b1;
      pending_evts[pending_evts.size() - 1] = tail;
    end
  endfunction

  function automatic void check_field(string label, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0h, actual %0h", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    evt_t want;
    if (rst) begin
      line_phase = LINE_START;
      line_field = FIELD_NONE;
      name_match = MATCH_START;
      cr_held = 1'b0;
      field_seen = 1'b0;
      data_nonempty = 1'b0;
      clear_name();
      pending_evts.delete();
    end else begin
      if (req_valid && req_ready) parse_req(req);
      if (evt_valid && evt_ready) begin
        if (pending_evts.size() == 0) begin
          errors++;
          $display("%0t ns: evt word expected none, actual kind %0d byte %0h last %0b",
                   $time, evt.kind, evt.byte_out, evt.last);
        end else begin
          want = pending_evts.pop_front();
          check_field("kind", 8'(want.kind), 8'(evt.kind));
          check_field("byte_out", want.byte_out, evt.byte_out);
          check_field("name_truncated", 8'(want.name_truncated), 8'(evt.name_truncated));
          check_field("flush_dispatched", 8'(want.flush_dispatched),
                      8'(evt.flush_dispatched));
          check_field("last", 8'(want.last), 8'(evt.last));
        end
      end
    end
    mismatches <= errors;
    outstanding <= pending_evts.size();
  end

endmodule

@@ bench/sse_event_stream_parser_core_tb.sv @@
// Testbench top for the event-stream parser: clock, reset, req stimulus, evt back-pressure.
// Depends on ssep_pkg, the parser core and ssep_stream_checker, which predicts and compares.
`timescale 1ns / 1ps
module sse_event_stream_parser_core_tb import ssep_pkg::*;;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  req_t req = '0;
  logic req_ready;
  logic evt_valid;
  logic evt_ready = 1'b0;
  evt_t evt;

  int mismatches;
  int outstanding;
  int words_sent = 0;
  bit send_idle_on = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sse_event_stream_parser_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  ssep_stream_checker stream_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .evt_valid   (evt_valid),
    .evt_ready   (evt_ready),
    .evt         (evt),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offer one req word and hold it until the handshake. A zero gap keeps valid
  // high straight into the next word, so valid only drops when a gap is drawn.
  // Idle spells toggle now and then, giving runs of back-to-back words.
  task automatic send_word(req_t w);
    int gap;
    if ($urandom_range(0, 24) == 0) send_idle_on = !send_idle_on;
    gap = send_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    req_t w;
    w.req_type = 1'b0;
    w.byte_in = b;
    send_word(w);
  endtask

  // Flush; the byte rides along but must be ignored.
  task automatic send_flush(logic [7:0] b);
    req_t w;
    w.req_type = 1'b1;
    w.byte_in = b;
    send_word(w);
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Random value bytes; an LF would end the line early, so it becomes a CR,
  // which also exercises CRs inside values.
  task automatic send_value(int len);
    int i;
    logic [7:0] b;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CH_LF) b = CH_CR;
      send_byte(b);
    end
  endtask

  // Mostly LF, often CRLF, sometimes a lone CR that the next line's first
  // byte turns back into an ordinary character.
  task automatic send_line_end();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 9) begin
      if (pick >= 6) send_byte(CH_CR);
      send_byte(CH_LF);
    end else begin
      send_byte(CH_CR);
    end
  endtask

  task automatic send_colon_value();
    send_byte(CH_COLON);
    if ($urandom_range(0, 1)) send_byte(CH_SPACE);
    send_value($urandom_range(0, 6));
  endtask

  // One random line, weighted towards well-formed fields so dispatches with
  // real names and data happen often; the tail is blank lines, noise and flushes.
  task automatic send_random_line();
    int    pick;
    string fname;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_text("data");
      send_colon_value();
      send_line_end();
    end else if (pick < 45) begin
      send_text("event");
      send_byte(CH_COLON);
      if ($urandom_range(0, 1)) send_byte(CH_SPACE);
      // now and then a long name that may run past the store and get cut
      if ($urandom_range(0, 3) == 0) send_value($urandom_range(28, 40));
      else send_value($urandom_range(0, 6));
      send_line_end();
    end else if (pick < 55) begin
      send_byte(CH_COLON);
      send_value($urandom_range(0, 5));
      send_line_end();
    end else if (pick < 70) begin
      case ($urandom_range(0, 7))
        0: fname = "id";
        1: fname = "retry";
        2: fname = "dat";
        3: fname = "events";
        4: fname = "Data";
        5: fname = "data";
        6: fname = "event";
        default: fname = "eve";
      endcase
      send_text(fname);
      // names without a colon: whole line is the name, value empty
      if (pick < 63) send_colon_value();
      send_line_end();
    end else if (pick < 85) begin
      send_line_end();
    end else if (pick < 92) begin
      send_flush(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Sender stands still until the checker has seen every predicted word.
  // outstanding is registered, so the first look is at the next edge after
  // the last handshake, once that word's predictions are in.
  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int random_target;
    bit mid_pause_done;
    mid_pause_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // blank line before any field: nothing at all
    send_byte(CH_LF);
    // data with NUL and 0xFF, a CR released before a byte, then CR CR LF:
    // first CR becomes data, the second is dropped by the LF
    send_text("data:");
    send_byte(8'h00);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // bare "data" line: newline since data is non-empty
    send_text("data");
    send_byte(CH_LF);
    // event name with the leading space stripped, then dispatch
    send_text("event: z");
    send_byte(CH_LF);
    send_byte(CH_LF);
    // partial line cut off by a flush, with the ignored byte all ones
    send_text("da");
    send_flush(8'hFF);
    // field seen, then a lone CR: flush drops it and the blank line dispatches
    send_text("x");
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_flush(8'h00);
    // flush with nothing pending
    send_flush(8'h5A);
    wait_drained();

    random_target = words_sent + 250;
    while (words_sent < random_target) begin
      if (!mid_pause_done && words_sent > random_target - 125) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
      send_random_line();
    end
    // close out any open event so the tail is flushed through
    send_flush(8'($urandom_range(0, 255)));

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // evt side: random stalls per word, idle-free spells, and two long holds so
  // the command queue fills and req_ready has to fall while words are offered.
  initial begin
    int  gap;
    int  taken;
    bit  idle_on;
    taken = 0;
    idle_on = 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 24) == 0) idle_on = !idle_on;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (taken == 40 || taken == 250) gap = 300;
      if (gap > 0) begin
        evt_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      evt_ready <= 1'b1;
      @(posedge clk);
      while (!evt_valid) @(posedge clk);
      taken++;
    end
  end

  // Hang guard, well beyond the slowest legal run.
  initial begin
    #6000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ssep_pkg.sv
rtl/ssep_ram.sv
rtl/ssep_front.sv
rtl/ssep_fifo.sv
rtl/ssep_back.sv
rtl/sse_event_stream_parser_core.sv
bench/ssep_stream_checker.sv
bench/sse_event_stream_parser_core_tb.sv
